// File: hdl/fft_pkg.sv
// Package: constants, types and twiddle function for the radix-2 FFT.
`default_nettype none
package fft_pkg;
  localparam int unsigned LogPointsDefault = 6;
  localparam int unsigned MaxLog = 6;
  localparam int unsigned SampleW = 16;
  localparam int unsigned DataW = 23;
  localparam int unsigned CmplxW = 2 * DataW;
  localparam int unsigned TwW = 16;

  typedef enum logic [2:0] {
    StLoad, StRead, StWait, StWrite, StEmitRd, StEmit
  } fft_state_e;

  typedef logic signed [DataW-1:0] data_t;

  function automatic logic signed [TwW-1:0] quarter_cos(input logic [4:0] k);
    logic signed [TwW-1:0] v;
    unique case (k)
      5'd0: v = 16'sd32767;  5'd1: v = 16'sd32610;  5'd2: v = 16'sd32138;
      5'd3: v = 16'sd31357;  5'd4: v = 16'sd30274;  5'd5: v = 16'sd28899;
      5'd6: v = 16'sd27246;  5'd7: v = 16'sd25330;  5'd8: v = 16'sd23170;
      5'd9: v = 16'sd20788;  5'd10: v = 16'sd18205; 5'd11: v = 16'sd15447;
      5'd12: v = 16'sd12540; 5'd13: v = 16'sd9512;  5'd14: v = 16'sd6393;
      5'd15: v = 16'sd3212;  default: v = 16'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [TwW-1:0] tw_cos(input logic [5:0] k);
    logic signed [TwW-1:0] v;
    if (k <= 6'd16) v = quarter_cos(k[4:0]);
    else if (k <= 6'd32) v = -quarter_cos(5'(6'd32 - k));
    else if (k <= 6'd48) v = -quarter_cos(5'(k - 6'd32));
    else v = quarter_cos(5'(7'd64 - {1'b0, k}));
    return v;
  endfunction

  function automatic logic signed [TwW-1:0] tw_sin(input logic [5:0] k);
    return tw_cos(6'(k + 6'd48));
  endfunction
endpackage
`default_nettype wire

// File: hdl/radix2_complex_fft.sv
// Top level of the radix-2 decimation-in-time complex FFT.
// Load: one sample per cycle; last sample starts the transform.
// Compute: (N/2)*log2(N) butterflies, each a read, wait and write state over the frame
// memories; the q result is written in the cycle after the p result.
// Emit: bins go out in order; each waits in a read state until the output register is free.
// Reset clears control and the mode register; the frame memories are not cleared.
`default_nettype none
module radix2_complex_fft #(
  parameter int unsigned LogPoints = fft_pkg::LogPointsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [15:0] sample_real_i,
  input  wire logic [15:0] sample_imag_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [22:0]      bin_real_o,
  output logic [22:0]      bin_imag_o,
  output logic [5:0]       bin_index_o,
  output logic             frame_end_o
);
  localparam int unsigned DW = fft_pkg::DataW;
  localparam int unsigned CW = fft_pkg::CmplxW;
  localparam int unsigned Rnd = 1 << (LogPoints - 1);

  fft_pkg::fft_state_e state;
  logic [5:0] load_addr, p_addr, q_addr, tw_k, emit_idx;
  logic emit_last, frame_done, inv_q, out_taken;
  logic [CW-1:0] p_rd, q_rd, p_wr, q_wr, in_word;
  logic we, we2_q, ram_we;
  logic [5:0] a_waddr, a_raddr, b_waddr, w2_addr_q, ram_waddr;
  logic [CW-1:0] a_wdata, b_wdata, w2_data_q, ram_wdata;
  logic [DW-1:0] er, ei;

  // mode only changes in the load state, not during compute or emit
  assign cfg_ready_o = state == fft_pkg::StLoad;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) inv_q <= 1'b0;
    else if (cfg_valid_i && cfg_ready_o) inv_q <= cfg_data_i;
  end

  assign out_taken = out_valid_o && out_ready_i;

  fft_ctrl #(.LogPoints(LogPoints)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .out_taken_i(out_taken), .out_full_i(out_valid_o), .state_o(state),
    .load_addr_o(load_addr), .p_addr_o(p_addr), .q_addr_o(q_addr),
    .tw_k_o(tw_k), .emit_idx_o(emit_idx), .emit_last_o(emit_last),
    .frame_done_o(frame_done)
  );

  assign in_word = {DW'($signed(sample_real_i)), DW'($signed(sample_imag_i))};
  assign we      = (state == fft_pkg::StLoad && in_valid_i) || state == fft_pkg::StWrite;
  assign a_waddr = (state == fft_pkg::StLoad) ? load_addr : p_addr;
  assign a_wdata = (state == fft_pkg::StLoad) ? in_word : p_wr;
  assign b_waddr = (state == fft_pkg::StLoad) ? load_addr : q_addr;
  assign b_wdata = (state == fft_pkg::StLoad) ? in_word : q_wr;
  assign a_raddr = (state == fft_pkg::StEmitRd || state == fft_pkg::StEmit) ? emit_idx : p_addr;

  // second write for the q result goes in the next cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) we2_q <= 1'b0;
    else we2_q <= state == fft_pkg::StWrite;
  end
  always_ff @(posedge clk_i) begin
    w2_addr_q <= b_waddr;
    w2_data_q <= b_wdata;
  end

  assign ram_we    = we || we2_q;
  assign ram_waddr = we2_q ? w2_addr_q : a_waddr;
  assign ram_wdata = we2_q ? w2_data_q : a_wdata;

  // two copies so that p and q are read in the same cycle
  fft_ram #(.Width(CW), .Depth(64)) u_ram_p (
    .clk_i, .we_i(ram_we), .waddr_i(ram_waddr), .wdata_i(ram_wdata),
    .raddr_i(a_raddr), .rdata_o(p_rd));
  fft_ram #(.Width(CW), .Depth(64)) u_ram_q (
    .clk_i, .we_i(ram_we), .waddr_i(ram_waddr), .wdata_i(ram_wdata),
    .raddr_i(q_addr), .rdata_o(q_rd));

  fft_bfly u_bfly (
    .clk_i, .p_i(p_rd), .q_i(q_rd), .tw_k_i(tw_k), .inv_i(inv_q),
    .p_o(p_wr), .q_o(q_wr));

  assign er = inv_q ? DW'(($signed({p_rd[2*DW-1], p_rd[2*DW-1:DW]})
                           + $signed((DW+1)'(Rnd))) >>> LogPoints)
                    : p_rd[2*DW-1:DW];
  assign ei = inv_q ? DW'(($signed({p_rd[DW-1], p_rd[DW-1:0]})
                           + $signed((DW+1)'(Rnd))) >>> LogPoints)
                    : p_rd[DW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (state == fft_pkg::StEmit) out_valid_o <= 1'b1;
    else if (out_taken) out_valid_o <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (state == fft_pkg::StEmit) begin
      bin_real_o  <= er;
      bin_imag_o  <= ei;
      bin_index_o <= emit_idx;
      frame_end_o <= emit_last;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state == fft_pkg::StEmit |-> !out_valid_o || out_taken) else $error("bin overwritten");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_done |=> out_valid_o && frame_end_o) else $error("frame end missing");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("bin dropped");
endmodule
`default_nettype wire

// File: hdl/fft_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module fft_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// File: hdl/fft_bfly.sv
// Butterfly datapath: registered twiddle products, then add and subtract.
`default_nettype none
module fft_bfly (
  input  wire logic                         clk_i,
  input  wire logic [fft_pkg::CmplxW-1:0]   p_i,
  input  wire logic [fft_pkg::CmplxW-1:0]   q_i,
  input  wire logic [5:0]                   tw_k_i,
  input  wire logic                         inv_i,
  output logic      [fft_pkg::CmplxW-1:0]   p_o,
  output logic      [fft_pkg::CmplxW-1:0]   q_o
);
  localparam int unsigned DW = fft_pkg::DataW;
  localparam int unsigned PW = DW + fft_pkg::TwW;
  logic signed [fft_pkg::TwW-1:0] wr, wi, wis;
  logic signed [DW-1:0] qr, qi, pr0, pi0;
  logic signed [PW-1:0] m_rr_q, m_ii_q, m_ri_q, m_ir_q;
  logic signed [DW-1:0] ar_q, ai_q;
  logic signed [PW+1:0] sr, si;
  logic signed [DW-1:0] tr, ti;

  assign wr  = fft_pkg::tw_cos(tw_k_i);
  assign wis = fft_pkg::tw_sin(tw_k_i);
  assign wi  = inv_i ? -wis : wis;
  assign qr  = q_i[2*DW-1:DW];
  assign qi  = q_i[DW-1:0];
  assign pr0 = p_i[2*DW-1:DW];
  assign pi0 = p_i[DW-1:0];

  always_ff @(posedge clk_i) begin
    m_rr_q <= wr * qr;
    m_ii_q <= wi * qi;
    m_ri_q <= wr * qi;
    m_ir_q <= wi * qr;
    ar_q   <= pr0;
    ai_q   <= pi0;
  end

  assign sr = (PW+2)'(m_rr_q) - (PW+2)'(m_ii_q) + (PW+2)'(16384);
  assign si = (PW+2)'(m_ri_q) + (PW+2)'(m_ir_q) + (PW+2)'(16384);
  assign tr = DW'(sr >>> 15);
  assign ti = DW'(si >>> 15);
  assign p_o = {DW'(ar_q + tr), DW'(ai_q + ti)};
  assign q_o = {DW'(ar_q - tr), DW'(ai_q - ti)};
endmodule
`default_nettype wire

// File: hdl/fft_ctrl.sv
// Sequencer: bit-reversed load addressing, butterfly addressing, and bin emission.
`default_nettype none
module fft_ctrl #(
  parameter int unsigned LogPoints = fft_pkg::LogPointsDefault
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire logic         out_taken_i,
  input  wire logic         out_full_i,
  output fft_pkg::fft_state_e state_o,
  output logic [5:0]        load_addr_o,
  output logic [5:0]        p_addr_o,
  output logic [5:0]        q_addr_o,
  output logic [5:0]        tw_k_o,
  output logic [5:0]        emit_idx_o,
  output logic              emit_last_o,
  output logic              frame_done_o
);
  localparam int unsigned N = 1 << LogPoints;
  localparam int unsigned HalfN = N / 2;
  fft_pkg::fft_state_e state_q, state_d;
  logic [6:0] cnt_q, cnt_d;
  logic [2:0] stage_q, stage_d;
  logic [5:0] bf_q, bf_d;
  logic [5:0] half, j, grp, p_lin, q_lin;

  function automatic logic [5:0] brev(input logic [5:0] x);
    logic [5:0] r;
    r = '0;
    for (int i = 0; i < LogPoints; i++) r[LogPoints-1-i] = x[i];
    return r;
  endfunction

  // stage_q counts 0..LogPoints-1; half = 2^stage
  assign half  = 6'(1 << stage_q);
  assign j     = bf_q & 6'(half - 6'd1);
  assign grp   = 6'(bf_q - j);
  assign p_lin = 6'((grp << 1) + j);
  assign q_lin = 6'(p_lin + half);
  // loaded in natural order; bit reversal applied on the load address
  assign load_addr_o = brev(cnt_q[5:0]);
  assign p_addr_o = p_lin;
  assign q_addr_o = q_lin;
  assign tw_k_o   = 6'(j << (fft_pkg::MaxLog - 1 - stage_q));
  assign emit_idx_o  = cnt_q[5:0];
  assign emit_last_o = cnt_q == 7'(N - 1);
  assign state_o = state_q;

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; stage_d = stage_q; bf_d = bf_q;
    unique case (state_q)
      fft_pkg::StLoad: if (in_valid_i) begin
        if (cnt_q == 7'(N - 1)) begin
          cnt_d = '0; state_d = fft_pkg::StRead; stage_d = '0; bf_d = '0;
        end else cnt_d = cnt_q + 7'd1;
      end
      fft_pkg::StRead:  state_d = fft_pkg::StWait;
      fft_pkg::StWait:  state_d = fft_pkg::StWrite;
      fft_pkg::StWrite: begin
        state_d = fft_pkg::StRead;
        if (bf_q == 6'(HalfN - 1)) begin
          bf_d = '0;
          if (stage_q == 3'(LogPoints - 1)) state_d = fft_pkg::StEmitRd;
          else stage_d = stage_q + 3'd1;
        end else bf_d = bf_q + 6'd1;
      end
      fft_pkg::StEmitRd: if (!out_full_i || out_taken_i) state_d = fft_pkg::StEmit;
      fft_pkg::StEmit: begin
        if (emit_last_o) begin
          cnt_d = '0; state_d = fft_pkg::StLoad;
        end else begin
          cnt_d = cnt_q + 7'd1; state_d = fft_pkg::StEmitRd;
        end
      end
      default: state_d = fft_pkg::StLoad;
    endcase
  end

  always_comb begin
    in_ready_o   = state_q == fft_pkg::StLoad;
    frame_done_o = state_q == fft_pkg::StEmit && emit_last_o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fft_pkg::StLoad; cnt_q <= '0; stage_q <= '0; bf_q <= '0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; stage_q <= stage_d; bf_q <= bf_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == fft_pkg::StLoad |-> cnt_q < 7'(N)) else $error("load count overrun");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != fft_pkg::StLoad |-> !in_ready_o) else $error("ready outside load");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == fft_pkg::StWrite |-> $past(state_q) == fft_pkg::StWait)
    else $error("butterfly sequence broken");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_q < 3'(LogPoints)) else $error("stage overrun");
endmodule
`default_nettype wire
